// ===== hdl/brq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the byte ring queue with seek.
package brq_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int BYTE_W    = 8;
  localparam int ACTION_W  = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_PEEK   = 3'd2,
    ACT_READ   = 3'd3,
    ACT_REMOVE = 3'd4,
    ACT_CLEAR  = 3'd5,
    ACT_SEEK   = 3'd6,
    ACT_NONE   = 3'd7
  } action_t;

endpackage

// ===== hdl/brq_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the queue's input and result transactions.
interface brq_in_if;
  logic                          valid;
  logic                          ready;
  logic [brq_pkg::ACTION_W-1:0]  action;
  logic [brq_pkg::BYTE_W-1:0]    value;
  logic [brq_pkg::BYTE_W-1:0]    index;

  modport source (output valid, output action, output value, output index, input ready);
  modport sink   (input valid, input action, input value, input index, output ready);
endinterface

interface brq_out_if;
  logic                        valid;
  logic                        ready;
  logic [brq_pkg::BYTE_W-1:0]  data_out;
  logic [brq_pkg::BYTE_W-1:0]  position;
  logic [brq_pkg::BYTE_W-1:0]  count;
  logic                        accepted;

  modport source (output valid, output data_out, output position, output count,
                  output accepted, input ready);
  modport sink   (input valid, input data_out, input position, input count,
                  input accepted, output ready);
endinterface

// ===== hdl/brq_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port slot memory, one write and one registered read per cycle.
module brq_ram #(
  parameter int DEPTH = brq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [brq_pkg::BYTE_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [brq_pkg::BYTE_W-1:0] wr_data
);

  logic [brq_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [brq_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/byte_ring_queue_with_seek.sv =====
`timescale 1ns / 1ps
// Top level of the byte ring queue with seek.
// Push, remove, clear, unused codes and rejected actions go from accept to the response state.
// Pop, peek and slot read that reach the memory first pass the read state, which takes the slot read.
// Seek reads one slot a cycle from the head to a match or count slots; empty skips the scan.
// One transaction in work at a time; ready returns as the result is loaded into the output
// register, so a stalled result holding that register also holds off the next transaction.
// Synchronous active-low reset empties the queue; no memory clearing pass is needed.
module byte_ring_queue_with_seek #(
  parameter int DEPTH = brq_pkg::DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  brq_in_if.sink    in_ch,
  brq_out_if.source out_ch
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = PW;
  localparam int AW = ((PW > brq_pkg::BYTE_W) ? PW : brq_pkg::BYTE_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_SEEK = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [CW-1:0] issue_cnt_r, issue_cnt_nxt;
  logic [CW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          cmp_valid_r, cmp_valid_nxt;
  logic [brq_pkg::BYTE_W-1:0] needle_r, needle_nxt;
  logic [brq_pkg::BYTE_W-1:0] res_data_r, res_data_nxt;
  logic [brq_pkg::BYTE_W-1:0] res_pos_r, res_pos_nxt;
  logic          res_acc_r, res_acc_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [brq_pkg::BYTE_W-1:0] out_data_r, out_data_nxt;
  logic [brq_pkg::BYTE_W-1:0] out_pos_r, out_pos_nxt;
  logic [brq_pkg::BYTE_W-1:0] out_count_r, out_count_nxt;
  logic          out_acc_r, out_acc_nxt;

  logic          rd_en, wr_en;
  logic [PW-1:0] rd_addr, wr_addr;
  logic [brq_pkg::BYTE_W-1:0] wr_data, rd_data;

  logic          in_fire, out_fire;
  logic [AW-1:0] peek_sum, peek_wrap, idx_ext, slot_off;
  logic          queue_full, queue_empty, peek_ok, read_ok;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign out_fire        = out_valid_r && out_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.count    = out_count_r;
  assign out_ch.accepted = out_acc_r;

  assign queue_full  = (count_r == CW'(DEPTH - 1));
  assign queue_empty = (count_r == '0);

  // peek address wraps at most once since offset < count < DEPTH
  assign peek_sum  = AW'(head_r) + AW'(in_ch.index);
  assign peek_wrap = (peek_sum >= AW'(DEPTH)) ? (peek_sum - AW'(DEPTH)) : peek_sum;
  assign peek_ok   = (AW'(in_ch.index) < AW'(count_r));

  // reads of slots outside the held region are rejected and return zero data
  assign idx_ext  = AW'(in_ch.index);
  assign slot_off = (idx_ext >= AW'(head_r)) ? (idx_ext - AW'(head_r))
                                             : (idx_ext + AW'(DEPTH) - AW'(head_r));
  assign read_ok  = (idx_ext < AW'(DEPTH)) && (slot_off < AW'(count_r));

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
  endfunction

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    scan_ptr_nxt  = scan_ptr_r;
    issue_cnt_nxt = issue_cnt_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_valid_nxt = 1'b0;
    needle_nxt    = needle_r;
    res_data_nxt  = res_data_r;
    res_pos_nxt   = res_pos_r;
    res_acc_nxt   = res_acc_r;
    out_valid_nxt = out_valid_r && !out_fire;
    out_data_nxt  = out_data_r;
    out_pos_nxt   = out_pos_r;
    out_count_nxt = out_count_r;
    out_acc_nxt   = out_acc_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_addr       = tail_r;
    wr_data       = in_ch.value;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_data_nxt = '0;
          res_pos_nxt  = '0;
          res_acc_nxt  = 1'b0;
          state_nxt    = S_RESP;
          case (brq_pkg::action_t'(in_ch.action))
            brq_pkg::ACT_PUSH: begin
              if (!queue_full) begin
                wr_en       = 1'b1;
                tail_nxt    = wrap_inc(tail_r);
                count_nxt   = count_r + CW'(1);
                res_acc_nxt = 1'b1;
              end
            end
            brq_pkg::ACT_POP: begin
              if (!queue_empty) begin
                rd_en       = 1'b1;
                rd_addr     = head_r;
                head_nxt    = wrap_inc(head_r);
                count_nxt   = count_r - CW'(1);
                res_acc_nxt = 1'b1;
                state_nxt   = S_RD;
              end
            end
            brq_pkg::ACT_PEEK: begin
              if (peek_ok) begin
                rd_en     = 1'b1;
                rd_addr   = PW'(peek_wrap);
                state_nxt = S_RD;
              end
            end
            brq_pkg::ACT_READ: begin
              if (read_ok) begin
                rd_en     = 1'b1;
                rd_addr   = PW'(idx_ext);
                state_nxt = S_RD;
              end
            end
            brq_pkg::ACT_REMOVE: begin
              if (!queue_empty) begin
                tail_nxt    = wrap_dec(tail_r);
                count_nxt   = count_r - CW'(1);
                res_acc_nxt = 1'b1;
              end
            end
            brq_pkg::ACT_CLEAR: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
            end
            brq_pkg::ACT_SEEK: begin
              if (!queue_empty) begin
                scan_ptr_nxt  = head_r;
                issue_cnt_nxt = '0;
                needle_nxt    = in_ch.value;
                state_nxt     = S_SEEK;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        res_data_nxt = rd_data;
        state_nxt    = S_RESP;
      end
      S_SEEK: begin
        if (cmp_valid_r && (rd_data == needle_r)) begin
          res_pos_nxt = brq_pkg::BYTE_W'(cmp_idx_r);
          state_nxt   = S_RESP;
        end else if (cmp_valid_r && (cmp_idx_r == count_r)) begin
          res_pos_nxt = '0;
          state_nxt   = S_RESP;
        end else if (issue_cnt_r != count_r) begin
          rd_en         = 1'b1;
          rd_addr       = scan_ptr_r;
          scan_ptr_nxt  = wrap_inc(scan_ptr_r);
          issue_cnt_nxt = issue_cnt_r + CW'(1);
          cmp_idx_nxt   = issue_cnt_r + CW'(1);
          cmp_valid_nxt = 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_data_r;
          out_pos_nxt   = res_pos_r;
          out_count_nxt = brq_pkg::BYTE_W'(count_r);
          out_acc_nxt   = res_acc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr_r  <= scan_ptr_nxt;
    issue_cnt_r <= issue_cnt_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    needle_r    <= needle_nxt;
    res_data_r  <= res_data_nxt;
    res_pos_r   <= res_pos_nxt;
    res_acc_r   <= res_acc_nxt;
    out_data_r  <= out_data_nxt;
    out_pos_r   <= out_pos_nxt;
    out_count_r <= out_count_nxt;
    out_acc_r   <= out_acc_nxt;
  end

  brq_ram #(
    .DEPTH (DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

// ===== hdl/brq_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertion checker for the byte ring queue, bound to the top level.
module brq_checker #(
  parameter int DEPTH = brq_pkg::DEPTH_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [brq_pkg::BYTE_W-1:0] data_out,
  input logic [brq_pkg::BYTE_W-1:0] position,
  input logic [brq_pkg::BYTE_W-1:0] count,
  input logic                       accepted
);

  localparam bit NARROW = (DEPTH <= 256);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(count))
    else $error("result transaction changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while one is in work");

  a_seek_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (position != '0) |->
      (data_out == '0) && !accepted && (!NARROW || (position <= count)))
    else $error("seek position inconsistent with result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!NARROW || (int'(count) <= DEPTH - 1)))
    else $error("count exceeds capacity");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind byte_ring_queue_with_seek brq_checker #(.DEPTH(DEPTH)) u_brq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .data_out  (out_ch.data_out),
  .position  (out_ch.position),
  .count     (out_ch.count),
  .accepted  (out_ch.accepted)
);
